// ----- design/bdq_pkg.sv -----
package bdq_pkg;

  localparam int DEPTH      = 16;
  localparam int ENTRY_BITS = 32;

  localparam int ACT_W      = 3;
  localparam int DATA_W     = 32;
  localparam int POS_W      = 4;
  localparam int CFG_W      = 5;
  localparam int OUT_CNT_W  = 5;

  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CMP_W      = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_BACK  = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_POP_BACK   = 3'd2,
    ACT_POP_FRONT  = 3'd3,
    ACT_REMOVE     = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUSH_BACK,
    OP_PUSH_FRONT,
    OP_POP_BACK,
    OP_POP_FRONT,
    OP_REMOVE
  } op_t;

  typedef struct packed {
    logic capture;
    logic exec;
    op_t  op;
  } ctl_cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             room;
    logic             nonempty;
    logic             pos_ok;
  } dp_status_t;

endpackage

// ----- design/bdq_ctrl.sv -----
module bdq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  bdq_pkg::dp_status_t status,
  output bdq_pkg::ctl_cmd_t   cmd
);
  import bdq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;
  op_t    op;

  always_comb begin
    op = OP_NONE;
    unique case (status.action)
      ACT_PUSH_BACK:  if (status.room)     op = OP_PUSH_BACK;
      ACT_PUSH_FRONT: if (status.room)     op = OP_PUSH_FRONT;
      ACT_POP_BACK:   if (status.nonempty) op = OP_POP_BACK;
      ACT_POP_FRONT:  if (status.nonempty) op = OP_POP_FRONT;
      ACT_REMOVE:     if (status.pos_ok)   op = OP_REMOVE;
      default:        op = OP_NONE;
    endcase
  end

  assign in_ready    = (state == S_IDLE);
  assign cmd.capture = in_valid && in_ready;
  assign cmd.exec    = (state == S_EXEC) && (!out_valid || out_ready);
  assign cmd.op      = op;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.capture) state <= S_EXEC;
        end
        S_EXEC: begin
          if (cmd.exec) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (cmd.exec) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- design/bdq_dp.sv -----
module bdq_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [bdq_pkg::CFG_W-1:0]       cfg_wr_data,
  input  logic [bdq_pkg::ACT_W-1:0]       action,
  input  logic [bdq_pkg::DATA_W-1:0]      entry_in,
  input  logic [bdq_pkg::POS_W-1:0]       position,
  input  bdq_pkg::ctl_cmd_t               cmd,
  output bdq_pkg::dp_status_t             status,
  output logic                            success,
  output logic [bdq_pkg::DATA_W-1:0]      entry_out,
  output logic [bdq_pkg::OUT_CNT_W-1:0]   count_after
);
  import bdq_pkg::*;

  logic [CFG_W-1:0]      cap_limit;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic [ACT_W-1:0]      action_q;
  logic [ENTRY_BITS-1:0] data_q;
  logic [POS_W-1:0]      pos_q;
  logic [ENTRY_BITS-1:0] store      [DEPTH];
  logic [ENTRY_BITS-1:0] store_next [DEPTH];
  logic [IDX_W-1:0]      last_idx;
  logic [CNT_W-1:0]      count_dec;
  logic [ENTRY_BITS-1:0] result;

  assign count_dec = count - 1'b1;
  assign last_idx  = count_dec[IDX_W-1:0];

  assign status.action   = action_q;
  assign status.room     = (CMP_W'(count) < CMP_W'(cap_limit)) &&
                           (CMP_W'(count) < CMP_W'(DEPTH));
  assign status.nonempty = (count != '0);
  assign status.pos_ok   = (CMP_W'(pos_q) < CMP_W'(count));

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      store_next[i] = store[i];
      case (cmd.op)
        OP_PUSH_BACK: begin
          if (CMP_W'(i) == CMP_W'(count)) store_next[i] = data_q;
        end
        OP_PUSH_FRONT: begin
          if (i == 0) store_next[i] = data_q;
          else        store_next[i] = store[i-1];
        end
        OP_POP_FRONT: begin
          if (i < DEPTH - 1) store_next[i] = store[i+1];
        end
        OP_REMOVE: begin
          if ((i < DEPTH - 1) && (CMP_W'(i) >= CMP_W'(pos_q))) store_next[i] = store[i+1];
        end
        default: store_next[i] = store[i];
      endcase
    end
  end

  always_comb begin
    count_next = count;
    result     = '0;
    case (cmd.op)
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        count_next = count + 1'b1;
        result     = data_q;
      end
      OP_POP_BACK: begin
        count_next = count_dec;
        result     = store[last_idx];
      end
      OP_POP_FRONT: begin
        count_next = count_dec;
        result     = store[0];
      end
      OP_REMOVE: begin
        count_next = count_dec;
      end
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_limit <= CAP_RESET;
      count     <= '0;
    end else begin
      if (cfg_wr_en) cap_limit <= cfg_wr_data;
      if (cmd.exec)  count     <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action_q <= action;
      data_q   <= ENTRY_BITS'(entry_in);
      pos_q    <= position;
    end
    if (cmd.exec) begin
      for (int i = 0; i < DEPTH; i++) begin
        store[i] <= store_next[i];
      end
      success     <= (cmd.op != OP_NONE);
      entry_out   <= DATA_W'(result);
      count_after <= OUT_CNT_W'(count_next);
    end
  end

endmodule

// ----- design/bounded_deque_with_remove.sv -----
// An input beat is held in the request register; the execute state then updates
// the shift-register store and the output register, waiting while an earlier
// result is unread. A new beat is taken only after the previous one has executed.
// A new input beat is taken while a finished result still waits in the output register.
// Reset (rst, synchronous): list empty, capacity limit 16, no result pending.
module bounded_deque_with_remove (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  action,
  input  logic [31:0] entry_in,
  input  logic [3:0]  position,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        success,
  output logic [31:0] entry_out,
  output logic [4:0]  count_after
);
  import bdq_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  bdq_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .action      (action),
    .entry_in    (entry_in),
    .position    (position),
    .cmd         (cmd),
    .status      (status),
    .success     (success),
    .entry_out   (entry_out),
    .count_after (count_after)
  );

`ifndef ASSERT_OFF
  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a request is in flight");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && (cmd.op == OP_PUSH_BACK || cmd.op == OP_PUSH_FRONT)) |-> status.room)
    else $error("push executed without room");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && (cmd.op == OP_POP_BACK || cmd.op == OP_POP_FRONT)) |-> status.nonempty)
    else $error("pop executed on empty list");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !success) |-> (entry_out == '0))
    else $error("failed action returned nonzero entry");
`endif

endmodule
